// ===== hdl/ckmt_pkg.sv =====
package ckmt_pkg;

    localparam int SLOTS      = 4096;
    localparam int ADDR_W     = $clog2(SLOTS);
    localparam int FILL_W     = $clog2(SLOTS + 1);
    localparam int KMER_LEN   = 31;
    localparam int KEY_W      = 62;
    localparam int WORD_W     = 2 * KMER_LEN;
    localparam int RUN_W      = 5;
    localparam int RUN_MAX    = 31;
    localparam int METRICS    = 13;
    localparam int MIDX_W     = 4;
    localparam int CNT_W      = 32;
    localparam int VAL_W      = 64;
    localparam int GRP_W      = 7;
    localparam int Q_OFFSET   = 33;
    localparam int MINQ_RESET = 20;
    localparam int PADDR_W    = 3;

    localparam logic [GRP_W-1:0] MASK_AB_OTHER = 7'd67;
    localparam logic [GRP_W-1:0] ONLY_A        = 7'd1;
    localparam logic [GRP_W-1:0] ONLY_B        = 7'd2;
    localparam logic [GRP_W-1:0] ONLY_OTHER    = 7'd64;

    localparam int M_A_ONLY     = 7;
    localparam int M_B_ONLY     = 8;
    localparam int M_OTHER_ONLY = 9;
    localparam int M_AB_AMB     = 10;
    localparam int M_LS_AMB     = 11;
    localparam int M_ALL        = 12;

    typedef enum logic [2:0] {
        ACT_LOAD        = 3'd0,
        ACT_BASE        = 3'd1,
        ACT_START       = 3'd2,
        ACT_END         = 3'd3,
        ACT_READ_COUNT  = 3'd4,
        ACT_READ_METRIC = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_SUMMARY,
        ST_RDCNT,
        ST_RDOUT
    } t_state;

    typedef struct packed {
        logic [2:0]       action;
        logic [KEY_W-1:0] marker_key;
        logic [GRP_W-1:0] group_mask;
        logic [7:0]       symbol;
        logic [7:0]       quality_char;
        logic             new_fragment;
        logic [11:0]      index;
    } t_cmd;

    typedef struct packed {
        logic             kind;
        logic [GRP_W-1:0] group_bits;
        logic             a_only;
        logic             b_only;
        logic             other_only;
        logic             ab_ambiguous;
        logic             ls_ambiguous;
        logic [VAL_W-1:0] value;
    } t_res;

    typedef struct packed {
        logic [ADDR_W-1:0] rd_addr;
        logic [ADDR_W-1:0] wr_addr;
        logic              key_we;
        logic [KEY_W-1:0]  key_wd;
        logic [GRP_W-1:0]  grp_wd;
        logic              cnt_we;
        logic [CNT_W-1:0]  cnt_wd;
        logic              hit_we;
        logic              hit_wd;
    } t_tbl_ctl;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [GRP_W-1:0] grp;
        logic [CNT_W-1:0] cnt;
        logic             hit;
    } t_tbl_rd;

    function automatic logic [2:0] base_code(input logic [7:0] ch);
        logic [2:0] r;
        case (ch)
            8'h41:   r = 3'b100;
            8'h43:   r = 3'b101;
            8'h47:   r = 3'b110;
            8'h54:   r = 3'b111;
            default: r = 3'b000;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/ckmt_table.sv =====
module ckmt_table (
    input  logic                i_clk,
    input  ckmt_pkg::t_tbl_ctl  i_ctl,
    output ckmt_pkg::t_tbl_rd   o_rd
);

    logic [ckmt_pkg::KEY_W-1:0] key_mem [ckmt_pkg::SLOTS];
    logic [ckmt_pkg::GRP_W-1:0] grp_mem [ckmt_pkg::SLOTS];
    logic [ckmt_pkg::CNT_W-1:0] cnt_mem [ckmt_pkg::SLOTS];
    logic                       hit_mem [ckmt_pkg::SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_ctl.key_we) begin
            key_mem[i_ctl.wr_addr] <= i_ctl.key_wd;
            grp_mem[i_ctl.wr_addr] <= i_ctl.grp_wd;
        end
        if (i_ctl.cnt_we) begin
            cnt_mem[i_ctl.wr_addr] <= i_ctl.cnt_wd;
        end
        if (i_ctl.hit_we) begin
            hit_mem[i_ctl.wr_addr] <= i_ctl.hit_wd;
        end
        o_rd.key <= key_mem[i_ctl.rd_addr];
        o_rd.grp <= grp_mem[i_ctl.rd_addr];
        o_rd.cnt <= cnt_mem[i_ctl.rd_addr];
        o_rd.hit <= hit_mem[i_ctl.rd_addr];
    end

endmodule

// ===== hdl/ckmt_kmer.sv =====
module ckmt_kmer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_shift,
    input  logic                       i_clear,
    input  logic [1:0]                 i_code,
    output logic [ckmt_pkg::KEY_W-1:0] o_canon,
    output logic                       o_full
);

    localparam logic [ckmt_pkg::WORD_W-1:0] WORD_MASK = '1;

    logic [ckmt_pkg::WORD_W-1:0] r_fw, n_fw, r_rv, n_rv;
    logic [ckmt_pkg::RUN_W-1:0]  r_run, n_run;
    logic [ckmt_pkg::WORD_W-1:0] rc_in;

    always_comb begin
        rc_in = '0;
        rc_in[ckmt_pkg::WORD_W-1 -: 2] = 2'd3 - i_code;
        n_fw  = r_fw;
        n_rv  = r_rv;
        n_run = r_run;
        if (i_clear) begin
            n_fw  = '0;
            n_rv  = '0;
            n_run = '0;
        end else if (i_shift) begin
            n_fw = ((r_fw << 2) | ckmt_pkg::WORD_W'(i_code)) & WORD_MASK;
            n_rv = (r_rv >> 2) | rc_in;
            if (r_run < ckmt_pkg::RUN_W'(ckmt_pkg::RUN_MAX)) begin
                n_run = r_run + 1'b1;
            end
        end
    end

    assign o_canon = (n_fw < n_rv) ? ckmt_pkg::KEY_W'(n_fw) : ckmt_pkg::KEY_W'(n_rv);
    assign o_full  = i_shift && !i_clear && (n_run >= ckmt_pkg::RUN_W'(ckmt_pkg::KMER_LEN));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw  <= '0;
            r_rv  <= '0;
            r_run <= '0;
        end else begin
            r_fw  <= n_fw;
            r_rv  <= n_rv;
            r_run <= n_run;
        end
    end

endmodule

// ===== hdl/canonical_kmer_marker_tally.sv =====
// canonical k-mer marker tally
// commands enter on i_cmd when i_start is high and o_busy is low
// actions: load marker, base, read start, end of input, read count, read metric
// results leave on o_res for one cycle, marked by o_valid; no back-pressure
// min_quality is set through the apb port at byte address 0
// a base that completes a full k-mer starts a search for its canonical key:
// the key memory is scanned one entry a cycle through its single read port
// a marker load scans the same way to reject duplicates
// a fragment flush sweeps all loaded markers, then the summary
// a count read-back passes through the RDCNT and RDOUT states; a metric read-back answers from idle
// all work is one command at a time; o_busy covers the whole scan
// reset empties the table, clears counts, metrics and k-mer words at once
// and sets min_quality to 20; markers past the fill count read as zero
module canonical_kmer_marker_tally (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  ckmt_pkg::t_cmd                i_cmd,
    output logic                          o_busy,
    output logic                          o_valid,
    output ckmt_pkg::t_res                o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ckmt_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    ckmt_pkg::t_state r_state, n_state;

    logic [6:0]                       r_minq;
    logic [ckmt_pkg::FILL_W-1:0]      r_fill, n_fill;
    logic [ckmt_pkg::FILL_W-1:0]      r_addr, n_addr;
    logic [ckmt_pkg::ADDR_W-1:0]      r_kaddr, n_kaddr;
    logic                             r_kval, n_kval;
    logic [ckmt_pkg::KEY_W-1:0]       r_target, n_target;
    logic [ckmt_pkg::GRP_W-1:0]       r_grp, n_grp;
    logic                             r_is_load, n_is_load;
    logic                             r_open, n_open;
    logic [ckmt_pkg::GRP_W-1:0]       r_bits, n_bits;
    logic [ckmt_pkg::VAL_W-1:0]       r_metric [ckmt_pkg::METRICS];
    logic [ckmt_pkg::VAL_W-1:0]       n_metric [ckmt_pkg::METRICS];
    logic                             r_valid, n_valid;
    ckmt_pkg::t_res                   r_res, n_res;

    ckmt_pkg::t_tbl_ctl               tbl_ctl;
    ckmt_pkg::t_tbl_rd                tbl_rd;

    logic                             accept;
    logic [2:0]                       bcode;
    logic                             good_base;
    logic                             k_shift, k_clear, k_full;
    logic [ckmt_pkg::KEY_W-1:0]       k_canon;
    logic                             issue, match, scan_done;
    logic [ckmt_pkg::GRP_W-1:0]       sel_bits;
    logic                             f_a, f_b, f_o, f_ab, f_ls;

    assign accept = i_start && !o_busy;
    assign o_busy = (r_state != ckmt_pkg::ST_IDLE);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {25'd0, r_minq} : 32'd0;

    assign bcode     = ckmt_pkg::base_code(i_cmd.symbol);
    assign good_base = bcode[2] &&
                       ({1'b0, i_cmd.quality_char} >= 9'(ckmt_pkg::Q_OFFSET) + {2'b0, r_minq});
    assign k_shift   = accept && (i_cmd.action == ckmt_pkg::ACT_BASE) && good_base;
    assign k_clear   = accept && (((i_cmd.action == ckmt_pkg::ACT_BASE) && !good_base) ||
                                  (i_cmd.action == ckmt_pkg::ACT_START));

    ckmt_kmer u_kmer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (k_shift),
        .i_clear (k_clear),
        .i_code  (bcode[1:0]),
        .o_canon (k_canon),
        .o_full  (k_full)
    );

    ckmt_table u_table (
        .i_clk (i_clk),
        .i_ctl (tbl_ctl),
        .o_rd  (tbl_rd)
    );

    assign issue     = (r_addr < r_fill);
    assign match     = r_kval && (tbl_rd.key == r_target);
    assign scan_done = !r_kval && !issue;

    assign sel_bits = r_bits & ckmt_pkg::MASK_AB_OTHER;
    assign f_a  = (sel_bits == ckmt_pkg::ONLY_A);
    assign f_b  = (sel_bits == ckmt_pkg::ONLY_B);
    assign f_o  = (sel_bits == ckmt_pkg::ONLY_OTHER);
    assign f_ab = r_bits[0] && r_bits[1];
    assign f_ls = r_bits[4] && (r_bits[2] || r_bits[3]);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ckmt_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_cmd.action)
                        ckmt_pkg::ACT_LOAD:       n_state = ckmt_pkg::ST_SCAN;
                        ckmt_pkg::ACT_BASE: begin
                            if (k_full) n_state = ckmt_pkg::ST_SCAN;
                        end
                        ckmt_pkg::ACT_START: begin
                            if (i_cmd.new_fragment && r_open) n_state = ckmt_pkg::ST_FLUSH;
                        end
                        ckmt_pkg::ACT_END: begin
                            if (r_open) n_state = ckmt_pkg::ST_FLUSH;
                        end
                        ckmt_pkg::ACT_READ_COUNT: n_state = ckmt_pkg::ST_RDCNT;
                        default:                  n_state = ckmt_pkg::ST_IDLE;
                    endcase
                end
            end
            ckmt_pkg::ST_SCAN: begin
                if (match || scan_done) n_state = ckmt_pkg::ST_IDLE;
            end
            ckmt_pkg::ST_FLUSH: begin
                if (scan_done) n_state = ckmt_pkg::ST_SUMMARY;
            end
            ckmt_pkg::ST_SUMMARY: n_state = ckmt_pkg::ST_IDLE;
            ckmt_pkg::ST_RDCNT:   n_state = ckmt_pkg::ST_RDOUT;
            ckmt_pkg::ST_RDOUT:   n_state = ckmt_pkg::ST_IDLE;
            default:              n_state = ckmt_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_fill    = r_fill;
        n_addr    = r_addr;
        n_kaddr   = r_kaddr;
        n_kval    = r_kval;
        n_target  = r_target;
        n_grp     = r_grp;
        n_is_load = r_is_load;
        n_open    = r_open;
        n_bits    = r_bits;
        n_metric  = r_metric;
        n_valid   = 1'b0;
        n_res     = r_res;
        tbl_ctl         = '0;
        tbl_ctl.rd_addr = r_addr[ckmt_pkg::ADDR_W-1:0];
        tbl_ctl.wr_addr = r_kaddr;
        case (r_state)
            ckmt_pkg::ST_IDLE: begin
                n_addr = '0;
                n_kval = 1'b0;
                n_bits = '0;
                if (accept) begin
                    case (i_cmd.action)
                        ckmt_pkg::ACT_LOAD: begin
                            n_target  = i_cmd.marker_key;
                            n_grp     = i_cmd.group_mask;
                            n_is_load = 1'b1;
                        end
                        ckmt_pkg::ACT_BASE: begin
                            n_target  = k_canon;
                            n_is_load = 1'b0;
                        end
                        ckmt_pkg::ACT_START: begin
                            n_open = 1'b1;
                        end
                        ckmt_pkg::ACT_END: begin
                            n_open = 1'b0;
                        end
                        ckmt_pkg::ACT_READ_COUNT: begin
                            n_addr = {1'b0, i_cmd.index};
                        end
                        ckmt_pkg::ACT_READ_METRIC: begin
                            n_valid      = 1'b1;
                            n_res        = '0;
                            n_res.kind   = 1'b1;
                            if (i_cmd.index < 12'(ckmt_pkg::METRICS)) begin
                                n_res.value = r_metric[i_cmd.index[ckmt_pkg::MIDX_W-1:0]];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ckmt_pkg::ST_SCAN: begin
                n_kval  = issue;
                n_kaddr = r_addr[ckmt_pkg::ADDR_W-1:0];
                if (issue) n_addr = r_addr + 1'b1;
                if (match && !r_is_load) begin
                    tbl_ctl.hit_we = 1'b1;
                    tbl_ctl.hit_wd = 1'b1;
                end
                if (scan_done && r_is_load && (r_fill < ckmt_pkg::FILL_W'(ckmt_pkg::SLOTS))) begin
                    tbl_ctl.wr_addr = r_fill[ckmt_pkg::ADDR_W-1:0];
                    tbl_ctl.key_we  = 1'b1;
                    tbl_ctl.key_wd  = r_target;
                    tbl_ctl.grp_wd  = r_grp;
                    tbl_ctl.cnt_we  = 1'b1;
                    tbl_ctl.cnt_wd  = '0;
                    tbl_ctl.hit_we  = 1'b1;
                    tbl_ctl.hit_wd  = 1'b0;
                    n_fill          = r_fill + 1'b1;
                end
            end
            ckmt_pkg::ST_FLUSH: begin
                n_kval  = issue;
                n_kaddr = r_addr[ckmt_pkg::ADDR_W-1:0];
                if (issue) n_addr = r_addr + 1'b1;
                if (r_kval && tbl_rd.hit) begin
                    tbl_ctl.cnt_we = 1'b1;
                    tbl_ctl.cnt_wd = tbl_rd.cnt + 1'b1;
                    tbl_ctl.hit_we = 1'b1;
                    tbl_ctl.hit_wd = 1'b0;
                    n_bits         = r_bits | tbl_rd.grp;
                end
            end
            ckmt_pkg::ST_SUMMARY: begin
                for (int j = 0; j < ckmt_pkg::GRP_W; j++) begin
                    if (r_bits[j]) n_metric[j] = r_metric[j] + 1'b1;
                end
                if (f_a)  n_metric[ckmt_pkg::M_A_ONLY]     = r_metric[ckmt_pkg::M_A_ONLY] + 1'b1;
                if (f_b)  n_metric[ckmt_pkg::M_B_ONLY]     = r_metric[ckmt_pkg::M_B_ONLY] + 1'b1;
                if (f_o)  n_metric[ckmt_pkg::M_OTHER_ONLY] =
                              r_metric[ckmt_pkg::M_OTHER_ONLY] + 1'b1;
                if (f_ab) n_metric[ckmt_pkg::M_AB_AMB]     = r_metric[ckmt_pkg::M_AB_AMB] + 1'b1;
                if (f_ls) n_metric[ckmt_pkg::M_LS_AMB]     = r_metric[ckmt_pkg::M_LS_AMB] + 1'b1;
                n_metric[ckmt_pkg::M_ALL] = r_metric[ckmt_pkg::M_ALL] + 1'b1;
                n_valid            = 1'b1;
                n_res              = '0;
                n_res.group_bits   = r_bits;
                n_res.a_only       = f_a;
                n_res.b_only       = f_b;
                n_res.other_only   = f_o;
                n_res.ab_ambiguous = f_ab;
                n_res.ls_ambiguous = f_ls;
            end
            ckmt_pkg::ST_RDCNT: begin
            end
            ckmt_pkg::ST_RDOUT: begin
                n_valid    = 1'b1;
                n_res      = '0;
                n_res.kind = 1'b1;
                if (issue) n_res.value = ckmt_pkg::VAL_W'(tbl_rd.cnt);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ckmt_pkg::ST_IDLE;
            r_minq   <= 7'(ckmt_pkg::MINQ_RESET);
            r_fill   <= '0;
            r_addr   <= '0;
            r_kval   <= 1'b0;
            r_open   <= 1'b0;
            r_valid  <= 1'b0;
            r_bits   <= '0;
            for (int j = 0; j < ckmt_pkg::METRICS; j++) begin
                r_metric[j] <= '0;
            end
        end else begin
            r_state  <= n_state;
            if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
                r_minq <= pwdata[6:0];
            end
            r_fill   <= n_fill;
            r_addr   <= n_addr;
            r_kval   <= n_kval;
            r_open   <= n_open;
            r_valid  <= n_valid;
            r_bits   <= n_bits;
            r_metric <= n_metric;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kaddr   <= n_kaddr;
        r_target  <= n_target;
        r_grp     <= n_grp;
        r_is_load <= n_is_load;
        r_res     <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
